// ===== rtl/core/segscan_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment scan serializer package
// Shared types, codes and lookup tables for the scan serializer.
// ----------------------------------------------------------------------------
package segscan_pkg;

  // request kind, carried in s_tuser
  typedef enum logic {
    KIND_SCAN  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  // display groups that take a number
  localparam logic [1:0] GROUP_LOW  = 2'd1;   // positions 0..2
  localparam logic [1:0] GROUP_HIGH = 2'd2;   // positions 3..5

  localparam int unsigned STORE_SLOTS = 8;
  localparam int unsigned SLOT_W      = 4;    // wide enough for 16 scan positions
  localparam int unsigned FRAME_BITS  = 16;

  localparam logic [6:0] ASCII_ZERO_HI = 7'h30;
  localparam logic [6:0] ASCII_SPACE   = 7'h20;
  localparam logic [6:0] ASCII_BLANK   = 7'h00;

  typedef logic [6:0] char_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // one-hot cathode drive per scan position; positions 8 and up drive none
  function automatic logic [7:0] cathode_code(input logic [SLOT_W-1:0] slot);
    logic [7:0] code;
    case (slot)
      4'd0:    code = 8'h04;
      4'd1:    code = 8'h02;
      4'd2:    code = 8'h01;
      4'd3:    code = 8'h08;
      4'd4:    code = 8'h20;
      4'd5:    code = 8'h40;
      4'd6:    code = 8'h80;
      4'd7:    code = 8'h10;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // segment pattern per character; characters without a glyph show blank
  function automatic logic [7:0] glyph(input char_t ch);
    logic [7:0] seg;
    case (ch)
      7'h2D:   seg = 8'h02;
      7'h2F:   seg = 8'h4A;
      7'h30:   seg = 8'hFC;
      7'h31:   seg = 8'h60;
      7'h32:   seg = 8'hDA;
      7'h33:   seg = 8'hF2;
      7'h34:   seg = 8'h66;
      7'h35:   seg = 8'hB6;
      7'h36:   seg = 8'hBE;
      7'h37:   seg = 8'hE0;
      7'h38:   seg = 8'hFE;
      7'h39:   seg = 8'hF6;
      7'h41:   seg = 8'hEE;
      7'h43:   seg = 8'h9C;
      7'h45:   seg = 8'h9E;
      7'h46:   seg = 8'h8E;
      7'h48:   seg = 8'h6E;
      7'h49:   seg = 8'h60;
      7'h4A:   seg = 8'h70;
      7'h4C:   seg = 8'h1C;
      7'h4F:   seg = 8'hFC;
      7'h50:   seg = 8'hCE;
      7'h53:   seg = 8'hB6;
      7'h55:   seg = 8'h7C;
      7'h62:   seg = 8'h3E;
      7'h63:   seg = 8'h1A;
      7'h64:   seg = 8'h7A;
      7'h67:   seg = 8'hF6;
      7'h68:   seg = 8'h2E;
      7'h69:   seg = 8'h20;
      7'h6A:   seg = 8'h70;
      7'h6B:   seg = 8'h1E;
      7'h6E:   seg = 8'h2A;
      7'h6F:   seg = 8'h3A;
      7'h72:   seg = 8'h0A;
      7'h74:   seg = 8'h1E;
      7'h75:   seg = 8'h38;
      7'h79:   seg = 8'h76;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] bit_reverse(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/segscan_digits.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal digit split
// Units, tens and hundreds digits of a 16-bit value, by reciprocal multiply.
// ----------------------------------------------------------------------------
module segscan_digits (
  input  wire logic [15:0]          value,
  output segscan_pkg::digits_t      digits
);

  // ceil(2^k / d), exact floor quotient for every 16-bit value
  localparam logic [32:0] RECIP_10   = 33'd104858;   // k = 20
  localparam logic [32:0] RECIP_100  = 33'd83887;    // k = 23
  localparam logic [32:0] RECIP_1000 = 33'd67109;    // k = 26

  logic [32:0] prod_10;
  logic [32:0] prod_100;
  logic [32:0] prod_1000;
  logic [12:0] q10;
  logic [9:0]  q100;
  logic [6:0]  q1000;

  assign prod_10   = 33'(value) * RECIP_10;
  assign prod_100  = 33'(value) * RECIP_100;
  assign prod_1000 = 33'(value) * RECIP_1000;

  assign q10   = prod_10[32:20];
  assign q100  = prod_100[32:23];
  assign q1000 = prod_1000[32:26];

  // each remainder is below ten, so the low four bits are exact
  assign digits.units    = 4'(value - 16'(q10) * 16'd10);
  assign digits.tens     = 4'(q10 - 13'(q100) * 13'd10);
  assign digits.hundreds = 4'(q100 - 10'(q1000) * 10'd10);

endmodule
`default_nettype wire

// ===== rtl/core/seven_segment_scan_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment scan serializer
// Character buffer for a multiplexed display, number writes and scan frames.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                     tuser  tlast
//  s_*      in   value, digit_count, display_group         kind   -
//  m_*      out  serial_bit                                -      strobe_after
//
//  A request is held in the input register. A number write then updates the
//  buffer and gives no output. A scan tick loads a 16-bit frame that leaves
//  one bit per accepted output cycle; the next frame loads in the cycle the
//  last bit is taken, if a scan request is waiting. Output stalls hold the
//  frame and, once the input register holds a scan request, s_tready.
//  Reset blanks the buffer and returns the scan to position 0.
// ----------------------------------------------------------------------------
module seven_segment_scan_serializer #(
  parameter int unsigned SCAN_POSITIONS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // value[15:0], digit_count[17:16], display_group[19:18]
  input  wire logic [0:0]  s_tuser,   // kind[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // serial_bit[0]
  output logic             m_tlast
);

  localparam int unsigned POS_W = (SCAN_POSITIONS > 1) ? $clog2(SCAN_POSITIONS) : 1;
  localparam int unsigned CNT_W = $clog2(segscan_pkg::FRAME_BITS);

  // input register
  logic                       in_valid;
  segscan_pkg::kind_t         in_kind;
  logic [15:0]                in_value;
  logic [1:0]                 in_count;
  logic [1:0]                 in_group;

  // frame shifter
  logic                       active;
  logic [segscan_pkg::FRAME_BITS-1:0] frame;
  logic [CNT_W-1:0]           bit_cnt;

  logic [POS_W-1:0]           pos;
  logic [POS_W-1:0]           pos_next;
  segscan_pkg::char_t         store [segscan_pkg::STORE_SLOTS];

  logic                       last_taken;
  logic                       load_ok;
  logic                       load;
  logic                       consume;
  logic                       write_en;
  segscan_pkg::digits_t       digits;
  segscan_pkg::char_t         ch_units;
  segscan_pkg::char_t         ch_tens;
  segscan_pkg::char_t         ch_hundreds;
  logic [segscan_pkg::SLOT_W-1:0] slot;
  segscan_pkg::char_t         scan_char;
  logic [segscan_pkg::FRAME_BITS-1:0] frame_next;

  assign last_taken = active && m_tready && (bit_cnt == CNT_W'(segscan_pkg::FRAME_BITS - 1));
  assign load_ok    = !active || last_taken;
  assign load       = in_valid && (in_kind == segscan_pkg::KIND_SCAN) && load_ok;
  assign write_en   = in_valid && (in_kind == segscan_pkg::KIND_WRITE);
  assign consume    = load || write_en;
  assign s_tready   = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= segscan_pkg::kind_t'(s_tuser[0]);
      in_value <= s_tdata[15:0];
      in_count <= s_tdata[17:16];
      in_group <= s_tdata[19:18];
    end
  end

  segscan_digits u_digits (
    .value  (in_value),
    .digits (digits)
  );

  // right-aligned; digits beyond the count become spaces
  always_comb begin
    ch_units    = (in_count != 2'd0) ? (segscan_pkg::ASCII_ZERO_HI | 7'(digits.units))
                                     : segscan_pkg::ASCII_SPACE;
    ch_tens     = in_count[1] ? (segscan_pkg::ASCII_ZERO_HI | 7'(digits.tens))
                              : segscan_pkg::ASCII_SPACE;
    ch_hundreds = (in_count == 2'd3) ? (segscan_pkg::ASCII_ZERO_HI | 7'(digits.hundreds))
                                     : segscan_pkg::ASCII_SPACE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < segscan_pkg::STORE_SLOTS; i++) begin
        store[i] <= segscan_pkg::ASCII_BLANK;
      end
    end else if (write_en) begin
      case (in_group)
        segscan_pkg::GROUP_LOW: begin
          store[0] <= ch_hundreds;
          store[1] <= ch_tens;
          store[2] <= ch_units;
        end
        segscan_pkg::GROUP_HIGH: begin
          store[3] <= ch_hundreds;
          store[4] <= ch_tens;
          store[5] <= ch_units;
        end
        default: begin
        end
      endcase
    end
  end

  // positions past the buffer read blank and drive no cathode
  always_comb begin
    slot       = segscan_pkg::SLOT_W'(pos);
    scan_char  = slot[3] ? segscan_pkg::ASCII_BLANK : store[slot[2:0]];
    frame_next = {segscan_pkg::cathode_code(slot),
                  segscan_pkg::bit_reverse(segscan_pkg::glyph(scan_char))};
    pos_next   = (pos == POS_W'(SCAN_POSITIONS - 1)) ? '0 : pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      bit_cnt <= '0;
    end else if (load) begin
      active  <= 1'b1;
      bit_cnt <= '0;
    end else if (active && m_tready) begin
      active  <= !last_taken;
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_next;
    end else if (active && m_tready) begin
      frame <= {frame[segscan_pkg::FRAME_BITS-2:0], 1'b0};
    end
  end

  assign m_tvalid = active;
  assign m_tdata  = {7'd0, frame[segscan_pkg::FRAME_BITS-1]};
  assign m_tlast  = (bit_cnt == CNT_W'(segscan_pkg::FRAME_BITS - 1));

  // a loaded frame is presented next cycle from its first bit
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> (m_tvalid && bit_cnt == '0))
    else $error("frame load did not start a fresh frame");

  // a stalled frame keeps its bit position
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(bit_cnt) && $stable(frame))
    else $error("frame moved while output stalled");

  // after the strobe bit the output goes idle unless a scan was waiting
  a_frame_ends: assert property (@(posedge clk) disable iff (rst)
    (last_taken && !load) |=> !m_tvalid)
    else $error("output stayed valid past the strobe bit");

  // scan position moves only with a scan, and wraps at the last position
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(pos))
    else $error("scan position moved without a scan");

  // number writes never reach the two top buffer slots
  a_top_slots: assert property (@(posedge clk) disable iff (rst)
    write_en |=> (store[6] == segscan_pkg::ASCII_BLANK && store[7] == segscan_pkg::ASCII_BLANK))
    else $error("number write reached an unused slot");

endmodule
`default_nettype wire
